FILE: rtl/core/smk_pkg.sv
// Shared types, constants and the arctangent step table for the swerve kinematics block.
package smk_pkg;

	localparam int WHEEL_LAT = 51;
	localparam int ATAN_TABLE_LEN = 24;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [1:0] {
		CFG_MODULE_X   = 2'd0,
		CFG_MODULE_Y   = 2'd1,
		CFG_RADIUS     = 2'd2,
		CFG_MIN_SPEED  = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic signed [15:0] cmd_vx;
		logic signed [15:0] cmd_vy;
		logic signed [15:0] cmd_omega;
	} cmd_t;

	typedef struct packed {
		logic [23:0]        fl_speed;
		logic signed [15:0] fl_angle;
		logic [23:0]        fr_speed;
		logic signed [15:0] fr_angle;
		logic [23:0]        bl_speed;
		logic signed [15:0] bl_angle;
		logic [23:0]        br_speed;
		logic signed [15:0] br_angle;
	} result_t;

	typedef struct packed {
		logic [23:0]        speed;
		logic signed [15:0] angle;
	} wheel_out_t;

	// atan(2^-i) scaled so that a full turn is 2^32.
	function automatic logic signed [33:0] atan_step(input logic [4:0] idx);
		logic signed [33:0] val;
		case (idx)
			5'd0:  val = 34'sd536870912;
			5'd1:  val = 34'sd316933406;
			5'd2:  val = 34'sd167458907;
			5'd3:  val = 34'sd85004756;
			5'd4:  val = 34'sd42667331;
			5'd5:  val = 34'sd21354465;
			5'd6:  val = 34'sd10679838;
			5'd7:  val = 34'sd5342293;
			5'd8:  val = 34'sd2671187;
			5'd9:  val = 34'sd1335599;
			5'd10: val = 34'sd667544;
			5'd11: val = 34'sd333772;
			5'd12: val = 34'sd166886;
			5'd13: val = 34'sd83443;
			5'd14: val = 34'sd41721;
			5'd15: val = 34'sd20860;
			5'd16: val = 34'sd10430;
			5'd17: val = 34'sd5215;
			5'd18: val = 34'sd2607;
			5'd19: val = 34'sd1303;
			5'd20: val = 34'sd651;
			5'd21: val = 34'sd325;
			5'd22: val = 34'sd162;
			5'd23: val = 34'sd81;
			default: val = 34'sd0;
		endcase
		return val;
	endfunction

endpackage

FILE: rtl/core/swerve_module_kinematics_top.sv
// Top level of the swerve drive inverse kinematics block: four wheel pipelines and config.
// A command is taken in every cycle at which start is high; busy never rises. Each
// command produces one result, marked by done, in order. The latency is set by the square
// root (18 stages) followed by the speed divider (28 stages); the steering angle rotation
// runs alongside them. The result cannot be held off by the receiver. Configuration
// writes act at once and are meant to be made while no command is in flight.
module swerve_module_kinematics_top import smk_pkg::*; #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cmd_t                  cmd,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_we,
	input  cfg_index_t            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [11:0] module_x_q, module_y_q;
	logic [9:0]  radius_q;
	logic [7:0]  min_speed_q;
	logic [9:0]  radius_eff;
	logic [WHEEL_LAT:0] vld_q;
	cmd_t        cmd_s0;
	logic signed [12:0] x_pos, y_pos;
	wheel_out_t  fl, fr, bl, br;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_x_q  <= 12'd300;
			module_y_q  <= 12'd300;
			radius_q    <= 10'd100;
			min_speed_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODULE_X:  module_x_q  <= cfg_wdata[11:0];
				CFG_MODULE_Y:  module_y_q  <= cfg_wdata[11:0];
				CFG_RADIUS:    radius_q    <= cfg_wdata[9:0];
				CFG_MIN_SPEED: min_speed_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[WHEEL_LAT-1:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s0 <= cmd;
		end
	end

	// A zero radius divides as if it were one.
	assign radius_eff = (radius_q == '0) ? 10'd1 : radius_q;
	assign x_pos = $signed({1'b0, module_x_q});
	assign y_pos = $signed({1'b0, module_y_q});

	smk_wheel #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_fl (
		.clk(clk), .cmd(cmd_s0), .pos_x(x_pos), .pos_y(y_pos),
		.radius(radius_eff), .min_speed(min_speed_q), .wheel(fl)
	);
	smk_wheel #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_fr (
		.clk(clk), .cmd(cmd_s0), .pos_x(x_pos), .pos_y(-y_pos),
		.radius(radius_eff), .min_speed(min_speed_q), .wheel(fr)
	);
	smk_wheel #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_bl (
		.clk(clk), .cmd(cmd_s0), .pos_x(-x_pos), .pos_y(y_pos),
		.radius(radius_eff), .min_speed(min_speed_q), .wheel(bl)
	);
	smk_wheel #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_br (
		.clk(clk), .cmd(cmd_s0), .pos_x(-x_pos), .pos_y(-y_pos),
		.radius(radius_eff), .min_speed(min_speed_q), .wheel(br)
	);

	assign done = vld_q[WHEEL_LAT];

	always_comb begin
		result.fl_speed = fl.speed;
		result.fl_angle = fl.angle;
		result.fr_speed = fr.speed;
		result.fr_angle = fr.angle;
		result.bl_speed = bl.speed;
		result.bl_angle = bl.angle;
		result.br_speed = br.speed;
		result.br_angle = br.angle;
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##52 done) else $error("transaction result missing");
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 52)) else $error("result without transaction");
	a_stop_angle: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.fl_speed == '0 |-> result.fl_angle == '0)
		else $error("stopped wheel has a steering angle");
`endif

endmodule

FILE: rtl/core/smk_wheel.sv
// Pipelined speed and steering angle computation for one wheel module.
module smk_wheel import smk_pkg::*; #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic               clk,
	input  cmd_t               cmd,
	input  logic signed [12:0] pos_x,
	input  logic signed [12:0] pos_y,
	input  logic [9:0]         radius,
	input  logic [7:0]         min_speed,
	output wheel_out_t         wheel
);

	localparam int N = ANGLE_ITERATIONS;
	localparam int ANG_DLY = 46 - ANGLE_ITERATIONS;
	localparam int SQ_STEPS = 18;
	localparam int DV_STEPS = 28;

	logic signed [28:0] prod_x_s1, prod_y_s1;
	logic signed [15:0] vx_s1, vy_s1;
	logic signed [19:0] wvx_s2, wvy_s2;
	logic signed [39:0] sqx_s3, sqy_s3;
	logic [35:0]        sum_s4;

	always_ff @(posedge clk) begin
		prod_x_s1 <= cmd.cmd_omega * pos_x;
		prod_y_s1 <= cmd.cmd_omega * pos_y;
		vx_s1     <= cmd.cmd_vx;
		vy_s1     <= cmd.cmd_vy;
		wvx_s2    <= 20'(vx_s1) - 20'(prod_y_s1 >>> 10);
		wvy_s2    <= 20'(vy_s1) + 20'(prod_x_s1 >>> 10);
		sqx_s3    <= wvx_s2 * wvx_s2;
		sqy_s3    <= wvy_s2 * wvy_s2;
		sum_s4    <= sqx_s3[35:0] + sqy_s3[35:0];
	end

	// Square root: two radicand bits per stage.
	logic [20:0] sq_rem  [0:SQ_STEPS];
	logic [17:0] sq_root [0:SQ_STEPS];
	logic [35:0] sq_n    [0:SQ_STEPS];

	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_n[0]    = sum_s4;

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		logic [20:0] rem_w, trial_w;
		assign rem_w   = {sq_rem[j][18:0], sq_n[j][35:34]};
		assign trial_w = {1'b0, sq_root[j], 2'b01};
		always_ff @(posedge clk) begin
			sq_n[j+1] <= {sq_n[j][33:0], 2'b00};
			if (rem_w >= trial_w) begin
				sq_rem[j+1]  <= rem_w - trial_w;
				sq_root[j+1] <= {sq_root[j][16:0], 1'b1};
			end else begin
				sq_rem[j+1]  <= rem_w;
				sq_root[j+1] <= {sq_root[j][16:0], 1'b0};
			end
		end
	end

	// Restoring divide of mag*1024 by the radius, one quotient bit per stage.
	logic [10:0] dv_rem [0:DV_STEPS];
	logic [27:0] dv_q   [0:DV_STEPS];
	logic [27:0] dv_n   [0:DV_STEPS];
	logic        dv_zf  [0:DV_STEPS];

	assign dv_rem[0] = '0;
	assign dv_q[0]   = '0;
	assign dv_n[0]   = {sq_root[SQ_STEPS], 10'd0};
	assign dv_zf[0]  = sq_root[SQ_STEPS] <= {10'd0, min_speed};

	for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
		logic [10:0] rem_w;
		assign rem_w = {dv_rem[k][9:0], dv_n[k][27]};
		always_ff @(posedge clk) begin
			dv_n[k+1]  <= {dv_n[k][26:0], 1'b0};
			dv_zf[k+1] <= dv_zf[k];
			if (rem_w >= {1'b0, radius}) begin
				dv_rem[k+1] <= rem_w - {1'b0, radius};
				dv_q[k+1]   <= {dv_q[k][26:0], 1'b1};
			end else begin
				dv_rem[k+1] <= rem_w;
				dv_q[k+1]   <= {dv_q[k][26:0], 1'b0};
			end
		end
	end

	// Vectoring rotation: a quarter-turn prerotation into the right half plane, then one
	// micro-rotation per stage.
	logic signed [55:0] cx [0:N];
	logic signed [55:0] cy [0:N];
	logic signed [33:0] cz [0:N];
	logic signed [55:0] px, py;

	assign px = {{4{wvx_s2[19]}}, wvx_s2, 32'd0};
	assign py = {{4{wvy_s2[19]}}, wvy_s2, 32'd0};

	always_ff @(posedge clk) begin
		if (px < 0) begin
			if (py >= 0) begin
				cx[0] <= py;
				cy[0] <= -px;
				cz[0] <= 34'sd1073741824;
			end else begin
				cx[0] <= -py;
				cy[0] <= px;
				cz[0] <= -34'sd1073741824;
			end
		end else begin
			cx[0] <= px;
			cy[0] <= py;
			cz[0] <= '0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (cy[i] >= 0) begin
				cx[i+1] <= cx[i] + (cy[i] >>> i);
				cy[i+1] <= cy[i] - (cx[i] >>> i);
				cz[i+1] <= cz[i] + atan_step(5'(i));
			end else begin
				cx[i+1] <= cx[i] - (cy[i] >>> i);
				cy[i+1] <= cy[i] + (cx[i] >>> i);
				cz[i+1] <= cz[i] - atan_step(5'(i));
			end
		end
	end

	// The angle is ready long before the speed; hold it until the divider is done.
	logic signed [15:0] ang_d [0:ANG_DLY];

	always_ff @(posedge clk) begin
		ang_d[0] <= 16'((cz[N] + 34'sd16384) >>> 15);
	end

	for (genvar k = 0; k < ANG_DLY; k++) begin : g_ang_dly
		always_ff @(posedge clk) begin
			ang_d[k+1] <= ang_d[k];
		end
	end

	always_ff @(posedge clk) begin
		wheel.speed <= (|dv_q[DV_STEPS][27:24]) ? 24'hFFFFFF : dv_q[DV_STEPS][23:0];
		wheel.angle <= dv_zf[DV_STEPS] ? 16'sd0 : ang_d[ANG_DLY];
	end

endmodule

FILE: test/swerve_module_kinematics_top_test.sv
// Self-checking testbench for the swerve drive inverse kinematics block.
`timescale 1ns / 1ps

module swerve_module_kinematics_top_test import smk_pkg::*; ();

	localparam int STEER_STEPS = 16;
	localparam int STALL_LIMIT = 5000;
	localparam longint SPEED_CAP = 64'd16777215;

	// atan(2^-i), full turn = 2^32
	localparam longint ATAN_LUT [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5342293, 2671187, 1335599, 667544, 333772,
		166886, 83443, 41721, 20860, 10430, 5215,
		2607, 1303, 651, 325, 162, 81
	};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	result_t result;
	logic cfg_we;
	cfg_index_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	swerve_module_kinematics_top #(.ANGLE_ITERATIONS(STEER_STEPS)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copies of the geometry registers.
	longint offset_x, offset_y, radius, slow_limit;

	cmd_t pending_cmds[$];
	result_t expected_results[$];
	int idle_pct;
	int errors;
	int cmds_sent;
	int results_seen;
	int stall_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint isqrt_floor(longint n);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] steer_angle(longint wx, longint wy);
		longint x, y, z, t, dx, dy;
		x = wx * 64'sd4294967296;
		y = wy * 64'sd4294967296;
		z = 0;
		// Pre-rotate the left half plane by a quarter turn.
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 64'sd1 <<< 30;
			end else begin
				x = -y; y = t; z = -(64'sd1 <<< 30);
			end
		end
		for (int i = 0; i < STEER_STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx; y = y - dy; z = z + ATAN_LUT[i];
			end else begin
				x = x - dx; y = y + dy; z = z - ATAN_LUT[i];
			end
		end
		z = (z + 16384) >>> 15;
		return z[15:0];
	endfunction

	function automatic wheel_out_t wheel_command(longint vx, longint vy, longint om,
			longint mx, longint my);
		longint wx, wy, mag, spd;
		wheel_out_t w;
		wx = vx - ((om * my) >>> 10);
		wy = vy + ((om * mx) >>> 10);
		mag = isqrt_floor(wx * wx + wy * wy);
		spd = (mag * 1024) / radius;
		w.speed = (spd > SPEED_CAP) ? SPEED_CAP[23:0] : spd[23:0];
		w.angle = (mag <= slow_limit) ? 16'sd0 : steer_angle(wx, wy);
		return w;
	endfunction

	function automatic result_t predict_result(cmd_t c);
		longint vx, vy, om;
		wheel_out_t w;
		result_t r;
		vx = c.cmd_vx;
		vy = c.cmd_vy;
		om = c.cmd_omega;
		w = wheel_command(vx, vy, om, offset_x, offset_y);
		r.fl_speed = w.speed; r.fl_angle = w.angle;
		w = wheel_command(vx, vy, om, offset_x, -offset_y);
		r.fr_speed = w.speed; r.fr_angle = w.angle;
		w = wheel_command(vx, vy, om, -offset_x, offset_y);
		r.bl_speed = w.speed; r.bl_angle = w.angle;
		w = wheel_command(vx, vy, om, -offset_x, -offset_y);
		r.br_speed = w.speed; r.br_angle = w.angle;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
	endtask

	task automatic check_wheel(string tag, logic [23:0] gs, logic signed [15:0] ga,
			logic [23:0] es, logic signed [15:0] ea);
		logic signed [15:0] d;
		if (gs !== es) report_mismatch({tag, " speed"}, gs, es);
		// The angle may differ by one unit, with wrap at a half turn.
		d = ga - ea;
		if ($isunknown(ga) || d > 16'sd1 || d < -16'sd1)
			report_mismatch({tag, " angle"}, ga, ea);
	endtask

	// Driver: one command transaction per accepting edge; the expectation is formed here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
		end else begin
			if (start && !busy) begin
				expected_results.insert(expected_results.size(), predict_result(cmd));
				void'(pending_cmds.pop_front());
				cmds_sent++;
			end
			if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				start <= 1'b1;
				cmd <= pending_cmds[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: each done strobe is one result transaction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				result_t e;
				e = expected_results.pop_front();
				check_wheel("fl", result.fl_speed, result.fl_angle, e.fl_speed, e.fl_angle);
				check_wheel("fr", result.fr_speed, result.fr_angle, e.fr_speed, e.fr_angle);
				check_wheel("bl", result.bl_speed, result.bl_angle, e.bl_speed, e.bl_angle);
				check_wheel("br", result.br_speed, result.br_angle, e.br_speed, e.br_angle);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding",
				expected_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_reg(cfg_index_t idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MODULE_X:  offset_x = val & 12'hFFF;
			CFG_MODULE_Y:  offset_y = val & 12'hFFF;
			CFG_RADIUS:    radius = ((val & 10'h3FF) == 0) ? 1 : (val & 10'h3FF);
			CFG_MIN_SPEED: slow_limit = val & 8'hFF;
			default: ;
		endcase
	endtask

	task automatic queue_cmd(int vx, int vy, int om);
		cmd_t c;
		c.cmd_vx = vx[15:0];
		c.cmd_vy = vy[15:0];
		c.cmd_omega = om[15:0];
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	task automatic queue_directed();
		queue_cmd(0, 0, 0);
		queue_cmd(1, 0, 0);
		queue_cmd(2, 0, 0);
		queue_cmd(0, -2, 0);
		queue_cmd(-5, 0, 0);        // straight back: half turn wraps
		queue_cmd(-32768, 0, 0);
		queue_cmd(32767, 32767, 0);
		queue_cmd(-32768, -32768, 0);
		queue_cmd(32767, -32768, 0);
		queue_cmd(0, 0, 32767);
		queue_cmd(0, 0, -32768);
		queue_cmd(-32768, -32768, -32768);
		queue_cmd(32767, 32767, 32767);
		queue_cmd(-32768, 32767, -32768);
		queue_cmd(1000, 0, 1024);
		queue_cmd(0, 1000, -1024);
		queue_cmd(-1, -1, 0);
		queue_cmd(-3, 1, 0);
	endtask

	task automatic queue_random(int n);
		int kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 9);
			if (kind < 6)
				queue_cmd($urandom, $urandom, $urandom);
			else if (kind < 8)
				queue_cmd($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
					$urandom_range(0, 60) - 30);
			else
				queue_cmd($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4, 0);
		end
	endtask

	task automatic drain();
		wait (pending_cmds.size() == 0 && expected_results.size() == 0);
		repeat (WHEEL_LAT + 8) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MODULE_X;
		cfg_wdata = '0;
		errors = 0;
		cmds_sent = 0;
		results_seen = 0;
		stall_cycles = 0;
		idle_pct = 21;
		offset_x = 300; offset_y = 300; radius = 100; slow_limit = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				1: begin
					write_reg(CFG_MODULE_X, 0); write_reg(CFG_MODULE_Y, 0);
					write_reg(CFG_RADIUS, 1); write_reg(CFG_MIN_SPEED, 0);
				end
				2: begin
					write_reg(CFG_MODULE_X, 4095); write_reg(CFG_MODULE_Y, 4095);
					write_reg(CFG_RADIUS, 1023); write_reg(CFG_MIN_SPEED, 255);
				end
				3: begin
					// A zero radius behaves as one.
					write_reg(CFG_MODULE_X, $urandom_range(0, 4095));
					write_reg(CFG_MODULE_Y, $urandom_range(0, 4095));
					write_reg(CFG_RADIUS, 0);
					write_reg(CFG_MIN_SPEED, $urandom_range(0, 255));
				end
				4: begin
					write_reg(CFG_MODULE_X, $urandom_range(0, 4095));
					write_reg(CFG_MODULE_Y, $urandom_range(0, 4095));
					write_reg(CFG_RADIUS, $urandom_range(1, 1023));
					write_reg(CFG_MIN_SPEED, $urandom_range(0, 255));
				end
				default: ;
			endcase
			queue_directed();
			// The middle phase runs back to back with no idle cycles.
			idle_pct = (phase == 2) ? 0 : 21;
			queue_random(200);
			drain();
		end

		$display("sent %0d commands over five geometry settings, checked %0d results",
			cmds_sent, results_seen);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb: failure");
		end
		$finish;
	end

endmodule
